// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

// ----- src/imu_fd_pkg.sv -----
`timescale 1ns / 1ps

package imu_fd_pkg;

    localparam logic [7:0] SYNC_BYTE      = 8'hA5;
    localparam int         PAYLOAD_LEN    = 16;
    localparam int         CNT_W          = $clog2(PAYLOAD_LEN);
    localparam int         QUEUE_DEPTH_DEF = 2;

    typedef enum logic [2:0] {
        PH_HUNT_FIRST  = 3'b001,
        PH_HUNT_SECOND = 3'b010,
        PH_COLLECT     = 3'b100
    } phase_t;

    typedef struct packed {
        logic        bad_chk;
        logic [15:0] accel_z;
        logic [15:0] accel_y;
        logic [15:0] accel_x;
        logic [15:0] yaw_rate;
        logic [15:0] yaw;
        logic [15:0] pitch;
        logic [15:0] roll;
    } frame_rec_t;

endpackage

// ----- src/imu_fd_front.sv -----
`timescale 1ns / 1ps

module imu_fd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,
    input  logic                 q_full,
    output logic                 q_push,
    output imu_fd_pkg::frame_rec_t q_wdata
);
    import imu_fd_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [15:0]       sum_reg, sum_next;
    logic [7:0]        pay_reg [PAYLOAD_LEN-1];
    logic              accept;
    logic              last_byte;
    logic [15:0]       chk_word;

    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign last_byte = (phase_reg == PH_COLLECT) && (cnt_reg == CNT_W'(PAYLOAD_LEN - 1));
    assign chk_word  = {rx_byte, pay_reg[PAYLOAD_LEN-2]};

    // Phase, count and running checksum.
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT_SECOND:
                begin
                    phase_next = (rx_byte == SYNC_BYTE) ? PH_COLLECT : PH_HUNT_FIRST;
                    cnt_next   = '0;
                    sum_next   = '0;
                end
                PH_COLLECT:
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    // High byte of yaw rate, yaw, pitch or roll: add the word.
                    if (cnt_reg[0] && cnt_reg >= CNT_W'(7) && cnt_reg <= CNT_W'(13))
                    begin
                        sum_next = sum_reg + {rx_byte, pay_reg[PAYLOAD_LEN-2]};
                    end
                    if (last_byte)
                    begin
                        phase_next = PH_HUNT_FIRST;
                        cnt_next   = '0;
                    end
                end
                default:
                begin
                    phase_next = (rx_byte == SYNC_BYTE) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
                    cnt_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT_FIRST;
            cnt_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
        end
    end

    // Shift line of payload bytes; the newest byte enters at the top.
    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == PH_COLLECT)
        begin
            for (int i = 0; i < PAYLOAD_LEN - 2; i++)
            begin
                pay_reg[i] <= pay_reg[i+1];
            end
            pay_reg[PAYLOAD_LEN-2] <= rx_byte;
        end
    end

    assign q_push           = accept && last_byte;
    assign q_wdata.bad_chk  = (sum_reg != chk_word);
    assign q_wdata.accel_z  = {pay_reg[1],  pay_reg[0]};
    assign q_wdata.accel_y  = {pay_reg[3],  pay_reg[2]};
    assign q_wdata.accel_x  = {pay_reg[5],  pay_reg[4]};
    assign q_wdata.yaw_rate = {pay_reg[7],  pay_reg[6]};
    assign q_wdata.yaw      = {pay_reg[9],  pay_reg[8]};
    assign q_wdata.pitch    = {pay_reg[11], pay_reg[10]};
    assign q_wdata.roll     = {pay_reg[13], pay_reg[12]};

endmodule

// ----- src/imu_fd_queue.sv -----
`timescale 1ns / 1ps

module imu_fd_queue #(
    parameter int DEPTH = imu_fd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  imu_fd_pkg::frame_rec_t wdata,
    input  logic                   pop,
    output imu_fd_pkg::frame_rec_t rdata,
    output logic                   full,
    output logic                   empty
);
    import imu_fd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_rec_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- src/imu_fd_back.sv -----
`timescale 1ns / 1ps

module imu_fd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  imu_fd_pkg::frame_rec_t q_rdata,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output imu_fd_pkg::frame_rec_t out_rec,
    output logic signed [16:0]     pitch_delta,
    output logic signed [16:0]     roll_delta
);
    import imu_fd_pkg::*;

    logic              out_vld_reg;
    frame_rec_t        rec_reg;
    logic signed [16:0] pitch_d_reg, roll_d_reg, pitch_d_next, roll_d_next;
    logic [15:0]       prev_pitch_reg, prev_roll_reg;

    // Load the output register when it is empty or being drained.
    assign q_pop = !q_empty && (!out_vld_reg || !out_stall);

    assign pitch_d_next = $signed({q_rdata.pitch[15], q_rdata.pitch})
                        - $signed({prev_pitch_reg[15], prev_pitch_reg});
    assign roll_d_next  = $signed({q_rdata.roll[15], q_rdata.roll})
                        - $signed({prev_roll_reg[15], prev_roll_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg    <= 1'b0;
            prev_pitch_reg <= '0;
            prev_roll_reg  <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                out_vld_reg <= 1'b1;
                if (!q_rdata.bad_chk)
                begin
                    prev_pitch_reg <= q_rdata.pitch;
                    prev_roll_reg  <= q_rdata.roll;
                end
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rec_reg     <= q_rdata;
            pitch_d_reg <= pitch_d_next;
            roll_d_reg  <= roll_d_next;
        end
    end

    assign out_valid   = out_vld_reg;
    assign out_rec     = rec_reg;
    assign pitch_delta = pitch_d_reg;
    assign roll_delta  = roll_d_reg;

endmodule

// ----- src/imu_frame_deframer.sv -----
`timescale 1ns / 1ps
// The frame record enters the queue on the last payload byte, then the output register.
// Throughput: one byte per cycle; the front stalls only while the frame queue is full.
// A frame is one record in a short queue, so a stalled result never blocks the byte stream
// until the queue fills (about one frame of 18 bytes per result).
// Reset (rst_n low, asynchronous): hunt for the first sync byte, empty queue, zero previous angles.
module imu_frame_deframer #(
    parameter int QUEUE_DEPTH = imu_fd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               frame_status,
    output logic signed [15:0] accel_z_raw,
    output logic signed [15:0] accel_y_raw,
    output logic signed [15:0] accel_x_raw,
    output logic signed [15:0] yaw_rate_raw,
    output logic signed [15:0] yaw_raw,
    output logic signed [15:0] pitch_raw,
    output logic signed [15:0] roll_raw,
    output logic signed [16:0] pitch_delta,
    output logic signed [16:0] roll_delta
);
    import imu_fd_pkg::*;
    `include "assert_macros.svh"

    // Front to queue: one record per completed frame.
    frame_rec_t q_wdata;
    frame_rec_t q_rdata;
    frame_rec_t out_rec;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;

    // Front: sync hunt, byte shift line and running checksum. Push the frame
    // record on the transfer of its last byte; hold off bytes while the queue is full.
    imu_fd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    // Queue: decouple the byte stream from the result channel.
    imu_fd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    // Back: compute angle deltas against the last good frame, advance the
    // stored angles on a good checksum only, and hold the result until transfer.
    imu_fd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_rec     (out_rec),
        .pitch_delta (pitch_delta),
        .roll_delta  (roll_delta)
    );

    assign frame_status = out_rec.bad_chk;
    assign accel_z_raw  = $signed(out_rec.accel_z);
    assign accel_y_raw  = $signed(out_rec.accel_y);
    assign accel_x_raw  = $signed(out_rec.accel_x);
    assign yaw_rate_raw = $signed(out_rec.yaw_rate);
    assign yaw_raw      = $signed(out_rec.yaw);
    assign pitch_raw    = $signed(out_rec.pitch);
    assign roll_raw     = $signed(out_rec.roll);

    // A frame record is never pushed into a full queue.
    `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, q_push, !q_full)
    // The back never pops an empty queue.
    `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, q_pop, !q_empty)
    // Frames are at least 18 bytes apart, so pushes never come back to back.
    `ASSERT_NEXT(a_push_spacing, clk, rst_n, q_push, !q_push)
    // Popping a record always leaves a result on the output.
    `ASSERT_NEXT(a_pop_shows, clk, rst_n, q_pop, out_valid)

endmodule
